// ===== sv/hslc_pkg.sv =====
// Shared types and constants for the HSL to RGB converter.
package hslc_pkg;

    // Hue sector picked by the front stage; SEC_GRAY is any hue above 360.
    typedef enum logic [2:0] {
        SEC_0,
        SEC_1,
        SEC_2,
        SEC_3,
        SEC_4,
        SEC_5,
        SEC_GRAY
    } hue_sector_t;

    // One classified pixel as it waits in the queue.
    typedef struct packed {
        hue_sector_t        sector;
        logic [5:0]         tri_w;
        logic signed [14:0] span_sat;
        logic [6:0]         light;
    } hslc_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } hslc_q_status_t;

    localparam int unsigned CHAN_W = 24;
    localparam int unsigned QUOT_W = 22;

    localparam logic signed [CHAN_W-1:0] C_SCALE  = 24'sd60;
    localparam logic signed [CHAN_W-1:0] M_SCALE  = 24'sd30;
    localparam logic signed [CHAN_W-1:0] L_SCALE  = 24'sd6000;
    // Smallest channel value that rounds to 255 or more.
    localparam logic signed [CHAN_W-1:0] SAT_LIMIT = 24'sd598824;
    localparam logic [27:0]              HALF_DEN  = 28'd300000;
    // Scaled numerator that yields exactly 255 after the reciprocal multiply.
    localparam logic [QUOT_W-1:0]        SAT_CODE  = 22'd2390625;
    // ceil(2^36 / 9375); exact floor division for any 22-bit numerator.
    localparam logic [22:0]              RECIP_M   = 23'd7330078;
    localparam logic [7:0]               ALPHA_VAL = 8'd255;

endpackage

// ===== sv/hslc_front.sv =====
// Front stage: takes pixels, finds the hue sector and the chroma product.
module hslc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [8:0]          hue_degrees,
    input  logic [6:0]          saturation_pct,
    input  logic [6:0]          lightness_pct,
    input  hslc_pkg::hslc_q_status_t q_status,
    output logic                push,
    output hslc_pkg::hslc_item_t push_data
);
    import hslc_pkg::*;

    logic        front_valid_reg;
    logic        front_valid_next;
    hslc_item_t  item_reg;
    hslc_item_t  item_next;

    hue_sector_t        sector;
    logic [8:0]         base;
    logic [8:0]         offset;
    logic signed [8:0]  two_l_minus;
    logic signed [8:0]  l_dev;
    logic signed [8:0]  span;
    logic signed [16:0] prod;

    assign in_stall = front_valid_reg && q_status.full;
    assign push     = front_valid_reg && !q_status.full;
    assign push_data = item_reg;

    always_comb
    begin
        if (hue_degrees < 9'd60)
            sector = SEC_0;
        else if (hue_degrees < 9'd120)
            sector = SEC_1;
        else if (hue_degrees < 9'd180)
            sector = SEC_2;
        else if (hue_degrees < 9'd240)
            sector = SEC_3;
        else if (hue_degrees < 9'd300)
            sector = SEC_4;
        else if (hue_degrees <= 9'd360)
            sector = SEC_5;
        else
            sector = SEC_GRAY;

        case (sector)
            SEC_0:   base = 9'd0;
            SEC_1:   base = 9'd60;
            SEC_2:   base = 9'd120;
            SEC_3:   base = 9'd180;
            SEC_4:   base = 9'd240;
            SEC_5:   base = 9'd300;
            default: base = 9'd0;
        endcase
        offset = hue_degrees - base;

        two_l_minus = $signed({1'b0, lightness_pct, 1'b0}) - 9'sd100;
        l_dev = (two_l_minus < 0) ? -two_l_minus : two_l_minus;
        span = 9'sd100 - l_dev;
        prod = 17'(span) * $signed({10'd0, saturation_pct});

        item_next.sector   = sector;
        item_next.span_sat = prod[14:0];
        item_next.light    = lightness_pct;
        // The ramp rises in even sectors and falls in odd ones.
        case (sector)
            SEC_1, SEC_3, SEC_5: item_next.tri_w = 6'(9'd60 - offset);
            SEC_GRAY:            item_next.tri_w = 6'd0;
            default:             item_next.tri_w = offset[5:0];
        endcase

        front_valid_next = in_stall ? front_valid_reg : in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
            item_reg <= item_next;
    end

endmodule

// ===== sv/hslc_queue.sv =====
// Short queue that decouples the front stage from the arithmetic pipeline.
module hslc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  hslc_pkg::hslc_item_t      push_data,
    input  logic                      pop,
    output hslc_pkg::hslc_item_t      pop_data,
    output hslc_pkg::hslc_q_status_t  q_status
);
    import hslc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    hslc_item_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== sv/hslc_back.sv =====
// Back pipeline: channel values, rounding to bytes, and the output register.
module hslc_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hslc_pkg::hslc_q_status_t q_status,
    input  hslc_pkg::hslc_item_t     pop_data,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               red_out,
    output logic [7:0]               green_out,
    output logic [7:0]               blue_out,
    output logic [7:0]               alpha_out
);
    import hslc_pkg::*;

    typedef logic signed [CHAN_W-1:0] chan_t;
    typedef logic [QUOT_W-1:0]        quot_t;

    logic  s1_valid_reg, s1_valid_next;
    logic  s2_valid_reg, s2_valid_next;
    logic  out_valid_reg, out_valid_next;
    logic  s1_ready, s2_ready, out_ready;

    chan_t v_reg [3];
    chan_t v_next [3];
    quot_t a_reg [3];
    quot_t a_next [3];
    logic [7:0] q_reg [3];
    logic [7:0] q_next [3];

    chan_t ps_w, c6, x6, m6;
    logic [27:0] num [3];
    logic [44:0] qp [3];

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop       = !q_status.empty && s1_ready;

    assign out_valid = out_valid_reg;
    assign red_out   = q_reg[0];
    assign green_out = q_reg[1];
    assign blue_out  = q_reg[2];
    assign alpha_out = ALPHA_VAL;

    // Stage 1: chroma, ramp and minimum, then the sector picks the channels.
    always_comb
    begin
        ps_w = CHAN_W'(pop_data.span_sat);
        c6   = ps_w * C_SCALE;
        x6   = ps_w * $signed({18'd0, pop_data.tri_w});
        m6   = $signed({17'd0, pop_data.light}) * L_SCALE - ps_w * M_SCALE;
        v_next[0] = m6;
        v_next[1] = m6;
        v_next[2] = m6;
        case (pop_data.sector)
            SEC_0:
            begin
                v_next[0] = m6 + c6;
                v_next[1] = m6 + x6;
            end
            SEC_1:
            begin
                v_next[0] = m6 + x6;
                v_next[1] = m6 + c6;
            end
            SEC_2:
            begin
                v_next[1] = m6 + c6;
                v_next[2] = m6 + x6;
            end
            SEC_3:
            begin
                v_next[1] = m6 + x6;
                v_next[2] = m6 + c6;
            end
            SEC_4:
            begin
                v_next[0] = m6 + x6;
                v_next[2] = m6 + c6;
            end
            SEC_5:
            begin
                v_next[0] = m6 + c6;
                v_next[2] = m6 + x6;
            end
            default:
            begin
                v_next[0] = m6;
            end
        endcase
    end

    // Stage 2: clamp and form (255*v + den/2) / 64; the rest of the divide follows.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num[i] = 28'(v_reg[i][19:0]) * 28'd255 + HALF_DEN;
            if (v_reg[i] <= 0)
                a_next[i] = '0;
            else if (v_reg[i] >= SAT_LIMIT)
                a_next[i] = SAT_CODE;
            else
                a_next[i] = num[i][27:6];
        end
    end

    // Stage 3: divide by 9375 through the reciprocal multiply.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qp[i]     = 45'(a_reg[i]) * 45'(RECIP_M);
            q_next[i] = qp[i][43:36];
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_ready ? pop : s1_valid_reg;
        s2_valid_next  = s2_ready ? s1_valid_reg : s2_valid_reg;
        out_valid_next = out_ready ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
            v_reg <= v_next;
        if (s2_ready)
            a_reg <= a_next;
        if (out_ready)
            q_reg <= q_next;
    end

endmodule

// ===== sv/hsl_to_rgb_converter.sv =====
// Top level of the HSL to RGB pixel converter.
//
// Input channel: in_valid / in_stall with hue_degrees, saturation_pct and
// lightness_pct; a pixel transfers on a clock edge with in_valid high and
// in_stall low. Output channel: out_valid / out_stall with red_out,
// green_out, blue_out and alpha_out; alpha_out is always 255.
// Hues above 360 give gray. Each channel is round(255 * v), ties up.
// Throughput is one pixel per clock whenever the receiver takes results.
// From the input transfer to out_valid a pixel passes the front register, the
// queue, the channel stage and the rounding stage, with the reciprocal
// multiply feeding the output register.
// When the receiver stalls, the output holds steady and the pipeline fills;
// the queue then fills and in_stall rises once the front register is blocked.
// Reset clears all valid flags and empties the queue; no pixel is pending
// after reset and the block accepts input on the first cycle.
module hsl_to_rgb_converter #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [8:0] hue_degrees,
    input  logic [6:0] saturation_pct,
    input  logic [6:0] lightness_pct,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out,
    output logic [7:0] alpha_out
);
    import hslc_pkg::*;

    hslc_q_status_t q_status;
    hslc_item_t     push_data;
    hslc_item_t     pop_data;
    logic           push;
    logic           pop;

    hslc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .hue_degrees    (hue_degrees),
        .saturation_pct (saturation_pct),
        .lightness_pct  (lightness_pct),
        .q_status       (q_status),
        .push           (push),
        .push_data      (push_data)
    );

    hslc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    hslc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out)
    );

endmodule

// ===== sv/hslc_checker.sv =====
// Port-level checks for the HSL to RGB converter and their bind.
module hslc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] red_out,
    input logic [7:0] green_out,
    input logic [7:0] blue_out,
    input logic [7:0] alpha_out
);

    // A stalled result stays offered with the same color.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_out)
            && $stable(green_out) && $stable(blue_out))
        else $error("stalled result changed");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> alpha_out == 8'd255)
        else $error("alpha is not opaque");

    // Nothing can reach the output in the first cycle out of reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result offered right after reset");

endmodule

bind hsl_to_rgb_converter hslc_checker u_hslc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .alpha_out (alpha_out)
);

// ===== test/tb_hsl_to_rgb_converter.sv =====
// Self-checking testbench for the HSL to RGB converter with directed and random pixels.
`timescale 1ns / 100ps

module tb_hsl_to_rgb_converter;

    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned LONG_HOLD   = 150;
    localparam int unsigned DRAIN_WAIT  = 12;
    localparam int unsigned NUM_ROWS    = 24;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgb_t;

    // One directed pixel; typed rows carry their color, the rest use the predictor.
    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] light;
        logic       typed;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [8:0] hue_degrees = '0;
    logic [6:0] saturation_pct = '0;
    logic [6:0] lightness_pct = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;

    rgb_t        expected_rgb_q[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    bit          hold_req = 1'b0;

    pixel_row_t directed_rows [0:NUM_ROWS-1] = '{
        '{9'd0,   7'd100, 7'd50,  1'b1, 8'd255, 8'd0,   8'd0},
        '{9'd120, 7'd100, 7'd50,  1'b1, 8'd0,   8'd255, 8'd0},
        '{9'd240, 7'd100, 7'd50,  1'b1, 8'd0,   8'd0,   8'd255},
        '{9'd360, 7'd100, 7'd50,  1'b1, 8'd255, 8'd0,   8'd0},
        '{9'd0,   7'd0,   7'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{9'd200, 7'd100, 7'd100, 1'b1, 8'd255, 8'd255, 8'd255},
        '{9'd361, 7'd0,   7'd50,  1'b1, 8'd128, 8'd128, 8'd128},
        '{9'd511, 7'd100, 7'd50,  1'b1, 8'd0,   8'd0,   8'd0},
        '{9'd60,  7'd100, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd180, 7'd100, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd300, 7'd100, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd30,  7'd100, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd359, 7'd100, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd90,  7'd50,  7'd25,  1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd150, 7'd75,  7'd60,  1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd210, 7'd33,  7'd67,  1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd270, 7'd10,  7'd90,  1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd330, 7'd99,  7'd1,   1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd0,   7'd127, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd45,  7'd100, 7'd127, 1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd511, 7'd127, 7'd127, 1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd100, 7'd127, 7'd0,   1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd0,   7'd0,   7'd127, 1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd256, 7'd85,  7'd42,  1'b0, 8'd0,   8'd0,   8'd0}
    };

    hsl_to_rgb_converter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .hue_degrees    (hue_degrees),
        .saturation_pct (saturation_pct),
        .lightness_pct  (lightness_pct),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .alpha_out      (alpha_out)
    );

    always #6 clk = ~clk;

    // Channel value is in units of 1/600000; round half up and clamp to a byte.
    function automatic logic [7:0] channel_byte(input longint level);
        longint q;
        if (level <= 0)
        begin
            return 8'd0;
        end
        q = (level * 255 + 300000) / 600000;
        if (q > 255)
        begin
            q = 255;
        end
        return q[7:0];
    endfunction

    function automatic rgb_t convert_pixel(input logic [8:0] hue, input logic [6:0] sat,
                                           input logic [6:0] light);
        longint h;
        longint s;
        longint l;
        longint offset;
        longint span;
        longint chroma;
        longint ramp;
        longint second;
        longint floor_lvl;
        longint rv;
        longint gv;
        longint bv;
        rgb_t   px;
        h = hue;
        s = sat;
        l = light;
        offset = 2 * l - 100;
        if (offset < 0)
        begin
            offset = -offset;
        end
        span = 100 - offset;
        chroma = span * s * 60;
        ramp = (h % 120) - 60;
        if (ramp < 0)
        begin
            ramp = -ramp;
        end
        ramp = 60 - ramp;
        second = span * s * ramp;
        floor_lvl = l * 6000 - chroma / 2;
        rv = floor_lvl;
        gv = floor_lvl;
        bv = floor_lvl;
        // Hues above 360 fall through every sector and come out gray.
        if (h < 60)
        begin
            rv += chroma; gv += second;
        end
        else if (h < 120)
        begin
            rv += second; gv += chroma;
        end
        else if (h < 180)
        begin
            gv += chroma; bv += second;
        end
        else if (h < 240)
        begin
            gv += second; bv += chroma;
        end
        else if (h < 300)
        begin
            rv += second; bv += chroma;
        end
        else if (h <= 360)
        begin
            rv += chroma; bv += second;
        end
        px.red = channel_byte(rv);
        px.green = channel_byte(gv);
        px.blue = channel_byte(bv);
        px.alpha = 8'd255;
        return px;
    endfunction

    task automatic send_pixel(input logic [8:0] h, input logic [6:0] s, input logic [6:0] l,
                              input logic typed, input rgb_t typed_rgb);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        hue_degrees <= h;
        saturation_pct <= s;
        lightness_pct <= l;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (typed)
        begin
            expected_rgb_q.push_back(typed_rgb);
        end
        else
        begin
            expected_rgb_q.push_back(convert_pixel(h, s, l));
        end
    endtask

    // Mostly in-range pixels, some on sector boundaries, the rest over the full field widths.
    task automatic pick_pixel(output logic [8:0] h, output logic [6:0] s, output logic [6:0] l);
        int unsigned kind;
        int          edge_hue;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            h = 9'($urandom_range(360));
            s = 7'($urandom_range(100));
            l = 7'($urandom_range(100));
        end
        else if (kind < 85)
        begin
            edge_hue = int'(60 * $urandom_range(6)) + int'($urandom_range(2)) - 1;
            if (edge_hue < 0)
            begin
                edge_hue = 0;
            end
            h = edge_hue[8:0];
            s = $urandom_range(1) ? 7'd100 : 7'($urandom_range(100));
            l = $urandom_range(1) ? 7'($urandom_range(2) * 50) : 7'($urandom_range(100));
        end
        else
        begin
            h = 9'($urandom_range(511));
            s = 7'($urandom_range(127));
            l = 7'($urandom_range(127));
        end
    endtask

    task automatic run_random(input int unsigned count, input int unsigned idle_v,
                              input int unsigned stall_v);
        logic [8:0] h;
        logic [6:0] s;
        logic [6:0] l;
        idle_pct = idle_v;
        stall_pct = stall_v;
        repeat (count)
        begin
            pick_pixel(h, s, l);
            send_pixel(h, s, l, 1'b0, '0);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] expected_v,
                               input logic [7:0] actual_v);
        if (actual_v !== expected_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected_v,
                     actual_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        rgb_t exp_px;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rgb_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, got %0d %0d %0d %0d", $time, red_out,
                         green_out, blue_out, alpha_out);
                error_count++;
            end
            else
            begin
                exp_px = expected_rgb_q.pop_front();
                check_field("red_out", exp_px.red, red_out);
                check_field("green_out", exp_px.green, green_out);
                check_field("blue_out", exp_px.blue, blue_out);
                check_field("alpha_out", exp_px.alpha, alpha_out);
            end
        end
    end

    // A requested long hold-off keeps the output stalled so the pipeline backs up.
    initial
    begin : receiver_stall
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL hsl_to_rgb_converter");
            $finish;
        end
    end

    initial
    begin
        rgb_t       typed_rgb;
        pixel_row_t row;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            typed_rgb = '{row.red, row.green, row.blue, 8'd255};
            send_pixel(row.hue, row.sat, row.light, row.typed, typed_rgb);
        end

        hold_req = 1'b1;
        run_random(300, 0, 0);
        run_random(300, 84, 0);
        run_random(300, 0, 84);
        run_random(350, 9, 9);
        in_valid <= 1'b0;

        while (expected_rgb_q.size() != 0)
        begin
            @(posedge clk);
        end
        stall_pct = 0;
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
        begin
            $display("PASS hsl_to_rgb_converter");
        end
        else
        begin
            $display("FAIL hsl_to_rgb_converter");
        end
        $finish;
    end

endmodule
